// ----- rtl/trpr_pkg.sv -----
// Shared types and constants for the TLS record payload redactor.
package trpr_pkg;

    typedef enum logic [2:0] {
        PH_IP   = 3'd0,
        PH_TCP  = 3'd1,
        PH_RHDR = 3'd2,
        PH_BODY = 3'd3,
        PH_PASS = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_last;
        logic [15:0] kept_length;
        logic        was_shortened;
    } trpr_result_t;

    localparam logic [15:0] POS_IP_VERSION  = 16'd14;
    localparam logic [15:0] POS_IP_PROTOCOL = 16'd23;
    localparam logic [6:0]  ETH_HDR_BYTES   = 7'd14;
    localparam logic [3:0]  IP_VERSION_4    = 4'd4;
    localparam logic [3:0]  MIN_HDR_WORDS   = 4'd5;
    localparam logic [7:0]  PROTO_TCP       = 8'd6;
    localparam logic [16:0] TCP_MIN_BYTES   = 17'd20;
    localparam logic [15:0] TCP_OFFSET_BYTE = 16'd12;
    localparam logic [15:0] MIN_CAPTURE     = 16'd54;
    localparam logic [7:0]  TLS_MAJOR       = 8'd3;
    localparam logic [7:0]  TYPE_APP_DATA   = 8'h17;
    localparam logic [7:0]  TYPE_ALERT      = 8'h15;
    localparam logic [17:0] REC_HDR_BYTES   = 18'd5;
    localparam logic [16:0] ALERT_KEPT_END  = 17'd7;
    localparam logic [15:0] ALERT_KEEP      = 16'd2;
    localparam logic [16:0] REL_TYPE        = 17'd0;
    localparam logic [16:0] REL_MAJOR       = 17'd1;
    localparam logic [16:0] REL_LEN_HI      = 17'd3;
    localparam logic [16:0] REL_LEN_LO      = 17'd4;

endpackage

// ----- rtl/tls_record_payload_redactor.sv -----
// Top level of the TLS record payload redactor: request registers around the parser.
//
// Usage: frame bytes enter on the s_axis channel, one request per byte, byte 0
// first, each carrying the frame's captured length; s_axis_tlast marks the final
// byte. Every request yields exactly one request on m_axis with the byte, zeroed
// inside application-data record bodies and inside alert bodies past two bytes.
// The request with m_axis_tlast set also carries the new kept length and the
// shortened flag; on other requests both are zero.
// An accepted byte passes through the input register, then the result register,
// before it is presented on m_axis.
// Throughput: one byte per cycle while m_axis is not stalled; the parse state
// update loops from the state registers through the byte decision and back.
// Reset (rst_n low, asynchronous): both registers empty, parser at the start of
// a frame. When m_axis_tready is low a full result register holds, the input
// register holds its byte, and s_axis_tready drops once both are full.
module tls_record_payload_redactor #(
    parameter int MAX_FRAME_BYTES = 65535
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] data_byte, [23:8] captured_length
    input  logic        s_axis_tlast,   // frame_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [23:8] kept_length,
                                        // [24] was_shortened, [31:25] zero
    output logic        m_axis_tlast    // out_last
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic [15:0] in_cap_reg;
    logic        in_last_reg;
    logic        out_valid_reg, out_valid_next;
    trpr_pkg::trpr_result_t out_reg;
    trpr_pkg::trpr_result_t result;
    logic        advance;
    logic        step;
    logic        s_accept;

    assign advance  = !out_valid_reg || m_axis_tready;
    assign step     = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = s_accept ? 1'b1 : (step ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    trpr_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .data_byte       (in_byte_reg),
        .captured_length (in_cap_reg),
        .frame_last      (in_last_reg),
        .result          (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_axis_tdata[7:0];
            in_cap_reg  <= s_axis_tdata[23:8];
            in_last_reg <= s_axis_tlast;
        end
        if (step)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_reg.was_shortened, out_reg.kept_length, out_reg.out_byte};
    assign m_axis_tlast  = out_reg.out_last;

endmodule

// ----- rtl/trpr_parser.sv -----
// Per-byte frame parser: parse state registers and redaction decision.
module trpr_parser #(
    parameter int MAX_FRAME_BYTES = 65535
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            data_byte,
    input  logic [15:0]           captured_length,
    input  logic                  frame_last,
    output trpr_pkg::trpr_result_t result
);

    localparam logic [15:0] MAX_POS = 16'(MAX_FRAME_BYTES);

    trpr_pkg::phase_t phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic [6:0]  tcp_start_reg, tcp_start_next;
    logic [16:0] rec_start_reg, rec_start_next;
    logic [7:0]  rec_type_reg, rec_type_next;
    logic [15:0] rec_len_reg, rec_len_next;
    logic [16:0] kept_end_reg, kept_end_next;
    logic        seen_reg, seen_next;

    logic [16:0] pos17;
    logic [16:0] cap17;
    logic [16:0] rel;
    logic [15:0] len_hdr;
    logic [17:0] hdr_end;
    logic [17:0] body_start;
    logic [17:0] body_end;
    logic [6:0]  tcp_cand;
    logic [15:0] tcp_off_pos;
    logic [15:0] pay_cand;
    logic [15:0] kept;
    logic        in_range;

    assign pos17       = {1'b0, pos_reg};
    assign cap17       = {1'b0, captured_length};
    assign rel         = pos17 - rec_start_reg;
    assign len_hdr     = {rec_len_reg[15:8], data_byte};
    assign hdr_end     = {1'b0, rec_start_reg} + trpr_pkg::REC_HDR_BYTES + {2'b00, len_hdr};
    assign body_start  = {1'b0, rec_start_reg} + trpr_pkg::REC_HDR_BYTES;
    assign body_end    = body_start + {2'b00, rec_len_reg};
    assign tcp_cand    = trpr_pkg::ETH_HDR_BYTES + {1'b0, data_byte[3:0], 2'b00};
    assign tcp_off_pos = {9'd0, tcp_start_reg} + trpr_pkg::TCP_OFFSET_BYTE;
    assign pay_cand    = {9'd0, tcp_start_reg} + {10'd0, data_byte[7:4], 2'b00};
    assign in_range    = (pos_reg != MAX_POS);

    // next state
    always_comb
    begin
        phase_next     = phase_reg;
        tcp_start_next = tcp_start_reg;
        rec_start_next = rec_start_reg;
        rec_type_next  = rec_type_reg;
        rec_len_next   = rec_len_reg;
        kept_end_next  = kept_end_reg;
        seen_next      = seen_reg;
        pos_next       = in_range ? (pos_reg + 16'd1) : pos_reg;
        if (in_range)
        begin
            case (phase_reg)
                trpr_pkg::PH_IP:
                begin
                    if (pos_reg == trpr_pkg::POS_IP_VERSION)
                    begin
                        if (data_byte[7:4] != trpr_pkg::IP_VERSION_4 ||
                            data_byte[3:0] < trpr_pkg::MIN_HDR_WORDS)
                        begin
                            phase_next = trpr_pkg::PH_PASS;
                        end
                        else
                        begin
                            tcp_start_next = tcp_cand;
                            if (({10'd0, tcp_cand} + trpr_pkg::TCP_MIN_BYTES) > cap17)
                            begin
                                phase_next = trpr_pkg::PH_PASS;
                            end
                        end
                    end
                    else if (pos_reg == trpr_pkg::POS_IP_PROTOCOL)
                    begin
                        phase_next = (data_byte == trpr_pkg::PROTO_TCP) ?
                                     trpr_pkg::PH_TCP : trpr_pkg::PH_PASS;
                    end
                end
                trpr_pkg::PH_TCP:
                begin
                    if (pos_reg == tcp_off_pos)
                    begin
                        if (data_byte[7:4] < trpr_pkg::MIN_HDR_WORDS ||
                            captured_length < trpr_pkg::MIN_CAPTURE ||
                            pay_cand >= captured_length)
                        begin
                            phase_next = trpr_pkg::PH_PASS;
                        end
                        else
                        begin
                            rec_start_next = {1'b0, pay_cand};
                            phase_next     = trpr_pkg::PH_RHDR;
                        end
                    end
                end
                trpr_pkg::PH_RHDR:
                begin
                    if (pos17 >= rec_start_reg)
                    begin
                        if (rel == trpr_pkg::REL_TYPE)
                        begin
                            rec_type_next = data_byte;
                        end
                        else if (rel == trpr_pkg::REL_MAJOR)
                        begin
                            if (data_byte != trpr_pkg::TLS_MAJOR)
                            begin
                                phase_next = trpr_pkg::PH_PASS;
                            end
                        end
                        else if (rel == trpr_pkg::REL_LEN_HI)
                        begin
                            rec_len_next = {data_byte, 8'h00};
                        end
                        else if (rel == trpr_pkg::REL_LEN_LO)
                        begin
                            rec_len_next = len_hdr;
                            if (hdr_end > {1'b0, cap17})
                            begin
                                phase_next = trpr_pkg::PH_PASS;
                            end
                            else
                            begin
                                seen_next = 1'b1;
                                if (rec_type_reg == trpr_pkg::TYPE_APP_DATA)
                                begin
                                    kept_end_next = body_start[16:0];
                                end
                                else if (rec_type_reg == trpr_pkg::TYPE_ALERT)
                                begin
                                    kept_end_next = (len_hdr >= trpr_pkg::ALERT_KEEP) ?
                                        (rec_start_reg + trpr_pkg::ALERT_KEPT_END) :
                                        hdr_end[16:0];
                                end
                                else
                                begin
                                    kept_end_next = hdr_end[16:0];
                                end
                                if (len_hdr == 16'd0)
                                begin
                                    rec_start_next = hdr_end[16:0];
                                end
                                else
                                begin
                                    phase_next = trpr_pkg::PH_BODY;
                                end
                            end
                        end
                    end
                end
                trpr_pkg::PH_BODY:
                begin
                    if ({2'b00, pos_reg} >= body_start &&
                        ({1'b0, pos17} + 18'd1) >= body_end)
                    begin
                        rec_start_next = body_end[16:0];
                        phase_next     = trpr_pkg::PH_RHDR;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (frame_last)
        begin
            phase_next     = trpr_pkg::PH_IP;
            pos_next       = 16'd0;
            tcp_start_next = 7'd0;
            rec_start_next = 17'd0;
            rec_type_next  = 8'd0;
            rec_len_next   = 16'd0;
            kept_end_next  = 17'd0;
            seen_next      = 1'b0;
        end
    end

    // outputs
    always_comb
    begin
        result.out_byte = data_byte;
        if (in_range && phase_reg == trpr_pkg::PH_BODY &&
            {2'b00, pos_reg} >= body_start)
        begin
            if (rec_type_reg == trpr_pkg::TYPE_APP_DATA ||
                (rec_type_reg == trpr_pkg::TYPE_ALERT &&
                 {2'b00, pos_reg} >= (body_start + 18'(trpr_pkg::ALERT_KEEP))))
            begin
                result.out_byte = 8'd0;
            end
        end
        result.out_last      = frame_last;
        result.kept_length   = 16'd0;
        result.was_shortened = 1'b0;
        kept = 16'd0;
        if (frame_last)
        begin
            kept = captured_length;
            if (seen_reg || (in_range && phase_reg == trpr_pkg::PH_RHDR &&
                             pos17 >= rec_start_reg && rel == trpr_pkg::REL_LEN_LO &&
                             hdr_end <= {1'b0, cap17}))
            begin
                kept = (in_range && phase_reg == trpr_pkg::PH_RHDR &&
                        pos17 >= rec_start_reg && rel == trpr_pkg::REL_LEN_LO &&
                        hdr_end <= {1'b0, cap17}) ?
                       ((rec_type_reg == trpr_pkg::TYPE_APP_DATA) ? body_start[15:0] :
                        (rec_type_reg == trpr_pkg::TYPE_ALERT) ?
                        ((len_hdr >= trpr_pkg::ALERT_KEEP) ?
                         16'(rec_start_reg + trpr_pkg::ALERT_KEPT_END) : hdr_end[15:0]) :
                        hdr_end[15:0]) :
                       kept_end_reg[15:0];
            end
            result.kept_length   = kept;
            result.was_shortened = (kept < captured_length);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= trpr_pkg::PH_IP;
            pos_reg       <= 16'd0;
            tcp_start_reg <= 7'd0;
            rec_start_reg <= 17'd0;
            rec_type_reg  <= 8'd0;
            rec_len_reg   <= 16'd0;
            kept_end_reg  <= 17'd0;
            seen_reg      <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            tcp_start_reg <= tcp_start_next;
            rec_start_reg <= rec_start_next;
            rec_type_reg  <= rec_type_next;
            rec_len_reg   <= rec_len_next;
            kept_end_reg  <= kept_end_next;
            seen_reg      <= seen_next;
        end
    end

endmodule

// ----- rtl/trpr_checker.sv -----
// Port-level checker for the TLS record payload redactor, bound to the top level.
module trpr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // drop input ready only when the output side is stalled
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // length and flag only on the last byte
    a_len_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[31:8] == 24'd0)
        else $error("kept length outside last byte");

    // advance an accepted request to the output when the output side does not stall
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && m_axis_tready) ##1 m_axis_tready
            |=> m_axis_tvalid)
        else $error("accepted byte did not reach the output");

endmodule

bind tls_record_payload_redactor trpr_checker u_trpr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
